[sv/calc_pkg.sv]
// ----------------------------------------------------------------------------
// calc_pkg
// Shared types, character codes and helpers for the two-operand calculator.
// ----------------------------------------------------------------------------
package calc_pkg;

  localparam int OPW     = 32;                 // operand and result width
  localparam int VALUE_W = 32;                 // width of the value port
  localparam int CNT_W   = $clog2(OPW + 1);    // divider step counter

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RS_OK       = 2'd0,
    RS_DIV_ZERO = 2'd1,
    RS_NO_OP    = 2'd2
  } res_status_t;

  typedef enum logic [5:0] {
    PH_LBLANK = 6'b000001,
    PH_LDIG   = 6'b000010,
    PH_LDONE  = 6'b000100,
    PH_RBLANK = 6'b001000,
    PH_RDIG   = 6'b010000,
    PH_RDONE  = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    S_PARSE = 4'b0001,
    S_EXEC  = 4'b0010,
    S_DIV   = 4'b0100,
    S_WAIT  = 4'b1000
  } ctrl_state_t;

  typedef struct packed {
    logic parse;     // non-terminator character taken
    logic finish;    // terminator taken
    logic exec;      // evaluate latched expression
    logic load_out;  // move result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic term;      // current character is the terminator
    logic need_div;  // latched expression needs the divider
    logic div_done;  // divider finished this cycle
  } dp_sts_t;

  function automatic op_t op_code_of(input logic [7:0] c);
    op_t r;
    case (c)
      CH_PLUS:  r = OP_ADD;
      CH_MINUS: r = OP_SUB;
      CH_STAR:  r = OP_MUL;
      CH_SLASH: r = OP_DIV;
      CH_PCT:   r = OP_MOD;
      default:  r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // acc*10 + digit, wrapped to the operand width
  function automatic logic [OPW-1:0] add_digit(input logic [OPW-1:0] acc,
                                               input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (acc << 3) + (acc << 1) + OPW'(d[3:0]);
  endfunction

  function automatic logic [OPW-1:0] abs_val(input logic [OPW-1:0] v);
    return v[OPW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

[sv/calc_div.sv]
// ----------------------------------------------------------------------------
// calc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module calc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [calc_pkg::OPW-1:0] dividend,
  input  logic [calc_pkg::OPW-1:0] divisor,
  output logic [calc_pkg::OPW-1:0] quotient,
  output logic [calc_pkg::OPW-1:0] remainder,
  output logic                     done
);

  logic [calc_pkg::OPW-1:0]   rem;
  logic [calc_pkg::OPW-1:0]   quo;
  logic [calc_pkg::OPW-1:0]   dvs;
  logic [calc_pkg::CNT_W-1:0] cnt;
  logic [calc_pkg::OPW:0]     shifted;
  logic [calc_pkg::OPW:0]     diff;
  logic                       busy;

  assign busy    = (cnt != '0);
  assign shifted = {rem, quo[calc_pkg::OPW-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == calc_pkg::CNT_W'(1));
      if (start) begin
        cnt <= calc_pkg::CNT_W'(calc_pkg::OPW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      // keep the partial remainder when the trial subtract goes negative
      if (!diff[calc_pkg::OPW]) begin
        rem <= diff[calc_pkg::OPW-1:0];
        quo <= {quo[calc_pkg::OPW-2:0], 1'b1};
      end else begin
        rem <= shifted[calc_pkg::OPW-1:0];
        quo <= {quo[calc_pkg::OPW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[sv/calc_dp.sv]
// ----------------------------------------------------------------------------
// calc_dp
// Operand parser, evaluation unit and output register.
// ----------------------------------------------------------------------------
module calc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    text_char,
  input  calc_pkg::dp_cmd_t             cmd,
  output calc_pkg::dp_sts_t             sts,
  output logic signed [calc_pkg::VALUE_W-1:0] value,
  output logic [1:0]                    status
);

  calc_pkg::phase_t         phase;
  calc_pkg::op_t            op_code;
  logic [calc_pkg::OPW-1:0] left_operand;
  logic [calc_pkg::OPW-1:0] right_magnitude;
  logic                     right_negative;

  // expression latched at the terminator
  calc_pkg::op_t            op_q;
  logic [calc_pkg::OPW-1:0] lhs;
  logic [calc_pkg::OPW-1:0] rhs;

  logic [calc_pkg::OPW-1:0] res;
  calc_pkg::res_status_t    res_status;

  logic signed [calc_pkg::VALUE_W-1:0] out_value;
  calc_pkg::res_status_t               out_status;

  calc_pkg::op_t            ch_op;
  logic                     ch_digit;
  logic                     ch_blank;
  logic                     div_start;
  logic [calc_pkg::OPW-1:0] quo;
  logic [calc_pkg::OPW-1:0] rem;
  logic                     div_done;

  assign ch_op    = calc_pkg::op_code_of(text_char);
  assign ch_digit = calc_pkg::is_digit(text_char);
  assign ch_blank = calc_pkg::is_blank(text_char);

  assign sts.term     = (text_char == calc_pkg::CH_NUL);
  assign sts.need_div = (op_q inside {calc_pkg::OP_DIV, calc_pkg::OP_MOD}) && (rhs != '0);
  assign sts.div_done = div_done;

  assign div_start = cmd.exec && sts.need_div;

  calc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (calc_pkg::abs_val(lhs)),
    .divisor  (calc_pkg::abs_val(rhs)),
    .quotient (quo),
    .remainder(rem),
    .done     (div_done)
  );

  // character parser
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      phase           <= calc_pkg::PH_LBLANK;
      op_code         <= calc_pkg::OP_NONE;
      left_operand    <= '0;
      right_magnitude <= '0;
      right_negative  <= 1'b0;
    end else if (cmd.parse) begin
      case (phase)
        calc_pkg::PH_LBLANK, calc_pkg::PH_LDIG, calc_pkg::PH_LDONE: begin
          if (ch_op != calc_pkg::OP_NONE) begin
            op_code <= ch_op;
            phase   <= calc_pkg::PH_RBLANK;
          end else if (phase == calc_pkg::PH_LBLANK && ch_blank) begin
            phase <= calc_pkg::PH_LBLANK;
          end else if (phase != calc_pkg::PH_LDONE && ch_digit) begin
            left_operand <= calc_pkg::add_digit(left_operand, text_char);
            phase        <= calc_pkg::PH_LDIG;
          end else begin
            phase <= calc_pkg::PH_LDONE;
          end
        end
        calc_pkg::PH_RBLANK: begin
          if (ch_blank) begin
            phase <= calc_pkg::PH_RBLANK;
          end else if (text_char == calc_pkg::CH_PLUS || text_char == calc_pkg::CH_MINUS) begin
            right_negative <= (text_char == calc_pkg::CH_MINUS);
            phase          <= calc_pkg::PH_RDIG;
          end else if (ch_digit) begin
            right_magnitude <= calc_pkg::add_digit(right_magnitude, text_char);
            phase           <= calc_pkg::PH_RDIG;
          end else begin
            phase <= calc_pkg::PH_RDONE;
          end
        end
        calc_pkg::PH_RDIG: begin
          if (ch_digit) begin
            right_magnitude <= calc_pkg::add_digit(right_magnitude, text_char);
          end else begin
            phase <= calc_pkg::PH_RDONE;
          end
        end
        default: begin
          phase <= calc_pkg::PH_RDONE;
        end
      endcase
    end
  end

  // latch the expression on the terminator
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      op_q <= op_code;
      lhs  <= left_operand;
      rhs  <= right_negative ? (~right_magnitude + 1'b1) : right_magnitude;
    end
  end

  // evaluation
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (op_q)
        calc_pkg::OP_ADD: begin
          res        <= lhs + rhs;
          res_status <= calc_pkg::RS_OK;
        end
        calc_pkg::OP_SUB: begin
          res        <= lhs - rhs;
          res_status <= calc_pkg::RS_OK;
        end
        calc_pkg::OP_MUL: begin
          res        <= lhs * rhs;
          res_status <= calc_pkg::RS_OK;
        end
        calc_pkg::OP_DIV, calc_pkg::OP_MOD: begin
          res <= '0;
          if (rhs == '0) begin
            res_status <= calc_pkg::RS_DIV_ZERO;
          end else begin
            res_status <= calc_pkg::RS_OK;
          end
        end
        default: begin
          res        <= '0;
          res_status <= calc_pkg::RS_NO_OP;
        end
      endcase
    end else if (div_done) begin
      // quotient sign is the xor of operand signs, remainder follows dividend
      if (op_q == calc_pkg::OP_DIV) begin
        res <= (lhs[calc_pkg::OPW-1] ^ rhs[calc_pkg::OPW-1]) ? (~quo + 1'b1) : quo;
      end else begin
        res <= lhs[calc_pkg::OPW-1] ? (~rem + 1'b1) : rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value  <= calc_pkg::VALUE_W'(signed'(res));
      out_status <= res_status;
    end
  end

  assign value  = out_value;
  assign status = out_status;

endmodule

[sv/calc_ctrl.sv]
// ----------------------------------------------------------------------------
// calc_ctrl
// Sequencer: character intake, evaluation, divide wait and output handshake.
// ----------------------------------------------------------------------------
module calc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  output logic                   result_valid,
  input  logic                   result_stall,
  input  calc_pkg::dp_sts_t      sts,
  output calc_pkg::dp_cmd_t      cmd,
  output calc_pkg::ctrl_state_t  state
);

  calc_pkg::ctrl_state_t state_next;
  logic                  accept;

  assign text_stall = (state != calc_pkg::S_PARSE);
  assign accept     = text_valid && !text_stall;

  always_comb begin
    cmd.parse    = accept && !sts.term;
    cmd.finish   = accept && sts.term;
    cmd.exec     = (state == calc_pkg::S_EXEC);
    cmd.load_out = (state == calc_pkg::S_WAIT) && (!result_valid || !result_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      calc_pkg::S_PARSE: if (cmd.finish) state_next = calc_pkg::S_EXEC;
      calc_pkg::S_EXEC:  state_next = sts.need_div ? calc_pkg::S_DIV : calc_pkg::S_WAIT;
      calc_pkg::S_DIV:   if (sts.div_done) state_next = calc_pkg::S_WAIT;
      calc_pkg::S_WAIT:  if (cmd.load_out) state_next = calc_pkg::S_PARSE;
      default:           state_next = calc_pkg::S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= calc_pkg::S_PARSE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/ascii_infix_expression_evaluator_top.sv]
// Sequence: ordinary characters go to the parser; a terminator latches the expression,
// the evaluate step follows, / and % with a nonzero divisor wait on the divider, and
// the result is loaded. Throughput: one character per cycle outside the stall; input
// stalls from terminator to result load, the divide wait set by the restoring divider.
// Reset: synchronous rst clears the parser, sequencer, divider counter and result valid.
// ----------------------------------------------------------------------------
// ascii_infix_expression_evaluator_top
// Two-operand integer calculator over an ASCII character stream.
// ----------------------------------------------------------------------------
module ascii_infix_expression_evaluator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  logic [7:0]         text_char,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic [1:0]         status
);

  calc_pkg::dp_cmd_t     cmd;
  calc_pkg::dp_sts_t     sts;
  calc_pkg::ctrl_state_t state;

  calc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sts         (sts),
    .cmd         (cmd),
    .state       (state)
  );

  calc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .text_char(text_char),
    .cmd      (cmd),
    .sts      (sts),
    .value    (value),
    .status   (status)
  );

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || !result_stall))
    else $error("result register overwritten while stalled");

  // divider completion only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == calc_pkg::S_DIV))
    else $error("divider done outside divide wait");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != 2'(calc_pkg::RS_OK)) |-> (value == '0))
    else $error("error status with nonzero value");

  // a terminator is followed by the evaluate step
  a_finish_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> cmd.exec)
    else $error("terminator not followed by evaluation");

endmodule
